FILE: rtl/vra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types and constants for the rectangle allocator in the frame store.
// ----------------------------------------------------------------------------
package vra_pkg;

   localparam int MaxEntries  = 512;
   localparam int StoreWidth  = 1024;
   localparam int StoreHeight = 512;
   localparam int IdxW        = $clog2(MaxEntries);
   localparam int CntW        = IdxW + 1;

   typedef enum logic [1:0] {
      MODE_ALLOC    = 2'd0,
      MODE_EXPLICIT = 2'd1,
      MODE_FREE     = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   // Pixel depth codes of a search allocate.
   typedef enum logic [1:0] {
      DEPTH_4    = 2'd0,
      DEPTH_8    = 2'd1,
      DEPTH_16   = 2'd2,
      DEPTH_NONE = 2'd3
   } depth_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  pos_x;
      logic [8:0]  pos_y;
      logic [11:0] size_w;
      logic [9:0]  size_h;
      logic [1:0]  colour_depth;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [9:0]  rect_x;
      logic [8:0]  rect_y;
      logic [10:0] rect_w;
      logic [9:0]  rect_h;
   } rsp_type;

   // Stored rectangle, 41 bits. A zero-width search result may sit at
   // column 1024, so x keeps one bit above the frame store.
   typedef struct packed {
      logic [10:0] x;
      logic [8:0]  y;
      logic [10:0] w;
      logic [9:0]  h;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROWSET,
      ST_ROW,
      ST_COLSTART,
      ST_COL,
      ST_SCAN_RD,
      ST_SCAN,
      ST_APPEND,
      ST_FREE_RD,
      ST_FREE_CMP,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: rtl/vra_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vra_table
// Entry table memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module vra_table (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [vra_pkg::IdxW-1:0] wr_addr,
   input  wire vra_pkg::entry_type     wr_data,
   input  wire logic [vra_pkg::IdxW-1:0] rd_addr,
   output vra_pkg::entry_type          rd_data
);

   vra_pkg::entry_type mem [vra_pkg::MaxEntries];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/vram_rect_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vram_rect_allocator_core
// Explicit allocate checks and appends the given rectangle; free compares the
// stored entries in turn and, on a match, moves the last entry into the matched
// slot; search allocate compares the entries in turn at each candidate column, walking
// the columns of each row and the rows in turn until a place is found or none is left.
// One word at a time: busy is high until the result strobe. The receiver
// cannot stall. Synchronous reset empties the table (count to zero).
// ----------------------------------------------------------------------------
module vram_rect_allocator_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire vra_pkg::req_type req_word,
   output logic                  rsp_strobe,
   output vra_pkg::rsp_type      rsp_word
);

   localparam int IW = vra_pkg::IdxW;
   localparam int CW = vra_pkg::CntW;

   vra_pkg::state_type state_ff, state_in;
   vra_pkg::req_type   req_ff, req_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic signed [13:0] x_ff, x_in;
   logic signed [12:0] y_ff, y_in;
   logic [10:0]        w_ff, w_in;
   logic [2:0]         mul_ff, mul_in;
   logic               big_ff, big_in;
   logic               ok_ff, ok_in;
   vra_pkg::rsp_type   rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic               wr_en;
   logic [IW-1:0]      wr_addr, rd_addr;
   vra_pkg::entry_type wr_data, rd_data;

   vra_table u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Working values shared by the sequencer.
   logic [12:0]        unit_w;
   logic [2:0]         unit_mul;
   logic [21:0]        area;
   logic signed [13:0] ex_w, hx;
   logic signed [12:0] ey_h;
   logic [9:0]         h;
   logic signed [13:0] rx_end, ry_end;
   logic               hit;
   logic [15:0]        page_chk;
   logic [12:0]        ey_w, ey_hh;

   assign h = req_ff.size_h;

   // Pixel width to store units; the full width is kept so oversize fails.
   always_comb begin
      unit_w   = '0;
      unit_mul = 3'd1;
      case (req_ff.colour_depth)
         vra_pkg::DEPTH_4: begin
            unit_w   = 13'((13'(req_ff.size_w) + 13'd7) >> 2) & 13'h1FFE;
            unit_mul = 3'd4;
         end
         vra_pkg::DEPTH_8: begin
            unit_w   = 13'((13'(req_ff.size_w) + 13'd3) >> 1) & 13'h1FFE;
            unit_mul = 3'd2;
         end
         default: begin
            unit_w   = (13'(req_ff.size_w) + 13'd1) & 13'h1FFE;
            unit_mul = 3'd1;
         end
      endcase
   end

   assign area = 22'(unit_w) * 22'(h);

   // Candidate (x_ff, y_ff, w_ff, h) vs read entry overlap; page check; explicit w/h.
   always_comb begin
      ex_w   = 14'(rd_data.x) + 14'(rd_data.w);
      ey_h   = 13'(rd_data.y) + 13'(rd_data.h);
      rx_end = x_ff + 14'(w_ff);
      ry_end = 14'(y_ff) + 14'(h);
      hx     = 14'(rd_data.x) - 14'(w_ff) + 14'sd1;
      hit    = (x_ff < ex_w) && (y_ff < ey_h) && (14'(rd_data.x) < rx_end)
               && (14'(rd_data.y) < ry_end);
      page_chk = 16'((13'(w_ff) + 13'(x_ff[5:0])) * 13'(mul_ff));
      ey_w   = 13'(req_ff.size_w) - 13'(req_ff.pos_x) + 13'd1;
      ey_hh  = 13'(req_ff.size_h) - 13'(req_ff.pos_y) + 13'd1;
   end

   // State and data registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= vra_pkg::ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      w_ff   <= w_in;
      mul_ff <= mul_in;
      big_ff <= big_in;
      ok_ff  <= ok_in;
      rsp_ff <= rsp_in;
   end

   // Sequencer: row walk, column walk, entry scan, append and free.
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      w_in      = w_ff;
      mul_in    = mul_ff;
      big_in    = big_ff;
      ok_in     = ok_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = IW'(count_ff);
      wr_data   = '{x: x_ff[10:0], y: y_ff[8:0], w: w_ff, h: h};
      rd_addr   = IW'(idx_ff);
      unique case (state_ff)
         vra_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_word;
               ok_in  = 1'b0;
               idx_in = '0;
               unique case (vra_pkg::mode_type'(req_word.mode))
                  vra_pkg::MODE_ALLOC:    state_in = vra_pkg::ST_ROWSET;
                  vra_pkg::MODE_EXPLICIT: state_in = vra_pkg::ST_APPEND;
                  vra_pkg::MODE_FREE:     state_in = vra_pkg::ST_FREE_RD;
                  default:                state_in = vra_pkg::ST_DONE;
               endcase
            end
         end
         vra_pkg::ST_ROWSET: begin
            w_in   = unit_w[10:0];
            mul_in = unit_mul;
            big_in = area >= 22'd1024;
            if (req_ff.colour_depth == vra_pkg::DEPTH_NONE
                || count_ff >= CW'(vra_pkg::MaxEntries)
                || unit_w > 13'(vra_pkg::StoreWidth) || h > 10'(vra_pkg::StoreHeight))
               state_in = vra_pkg::ST_DONE;
            else if (area >= 22'd1024) begin
               y_in = 13'(vra_pkg::StoreHeight) - 13'(h);
               state_in = vra_pkg::ST_ROW;
            end else if (13'(vra_pkg::StoreHeight) - 13'(h) <= 13'sd0)
               state_in = vra_pkg::ST_DONE;
            else begin
               y_in = '0;
               state_in = vra_pkg::ST_ROW;
            end
         end
         vra_pkg::ST_ROW: begin
            if (big_ff) begin
               // A row whose span crosses a page steps up; tall blocks jump.
               if (y_ff < 0) state_in = vra_pkg::ST_DONE;
               else if (13'(y_ff[7:0]) + 13'(h) <= 13'd256)
                  state_in = vra_pkg::ST_COLSTART;
               else if (h > 10'd256)
                  y_in = y_ff + 13'd256 - 13'(h) - 13'd1;
               else
                  y_in = y_ff - 13'sd1;
            end else begin
               if (13'(y_ff[7:0]) + 13'(h) <= 13'd255)
                  state_in = vra_pkg::ST_COLSTART;
               else begin
                  y_in = {y_ff[12:8] + 5'd1, 8'd0};
                  if (y_in >= 13'(vra_pkg::StoreHeight) - 13'(h))
                     state_in = vra_pkg::ST_DONE;
               end
            end
         end
         vra_pkg::ST_COLSTART: begin
            x_in     = 14'(vra_pkg::StoreWidth) - 14'(w_ff);
            state_in = vra_pkg::ST_COL;
         end
         vra_pkg::ST_COL: begin
            if (x_ff < 0) begin
               // Row exhausted: next row.
               if (big_ff) y_in = y_ff - 13'sd1;
               else y_in = y_ff + 13'sd1;
               if (big_ff || (y_ff + 13'sd1 < 13'(vra_pkg::StoreHeight) - 13'(h)))
                  state_in = vra_pkg::ST_ROW;
               else state_in = vra_pkg::ST_DONE;
            end else if (page_chk <= 16'd256) begin
               idx_in   = '0;
               state_in = vra_pkg::ST_SCAN_RD;
            end else x_in = x_ff - 14'sd1;
         end
         vra_pkg::ST_SCAN_RD: begin
            if (idx_ff >= count_ff) state_in = vra_pkg::ST_APPEND;
            else state_in = vra_pkg::ST_SCAN;
         end
         vra_pkg::ST_SCAN: begin
            if (hit) begin
               x_in     = ((hx < x_ff) ? hx : x_ff) - 14'sd1;
               state_in = vra_pkg::ST_COL;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = vra_pkg::ST_SCAN_RD;
            end
         end
         vra_pkg::ST_APPEND: begin
            if (req_ff.mode == vra_pkg::MODE_EXPLICIT) begin
               wr_data = '{x: 11'(req_ff.pos_x), y: req_ff.pos_y, w: ey_w[10:0],
                           h: ey_hh[9:0]};
               if (count_ff < CW'(vra_pkg::MaxEntries) && !ey_w[12] && ey_w != 0
                   && !ey_hh[12] && ey_hh != 0 && ey_w <= 13'(vra_pkg::StoreWidth)
                   && ey_hh <= 13'(vra_pkg::StoreHeight)) begin
                  wr_en = 1'b1;
                  ok_in = 1'b1;
               end
            end else begin
               wr_en = 1'b1;
               ok_in = 1'b1;
            end
            if (wr_en) count_in = count_ff + CW'(1);
            rsp_in   = '{ok: 1'b1, rect_x: wr_data.x[9:0], rect_y: wr_data.y,
                         rect_w: wr_data.w, rect_h: wr_data.h};
            if (!wr_en) rsp_in = '0;
            strobe_in = 1'b1;
            state_in  = vra_pkg::ST_IDLE;
         end
         vra_pkg::ST_FREE_RD: begin
            if (idx_ff >= count_ff) state_in = vra_pkg::ST_DONE;
            else state_in = vra_pkg::ST_FREE_CMP;
         end
         vra_pkg::ST_FREE_CMP: begin
            if (rd_data.x == 11'(req_ff.pos_x) && rd_data.y == req_ff.pos_y
                && 12'(rd_data.w) == req_ff.size_w && rd_data.h == req_ff.size_h) begin
               ok_in    = 1'b1;
               state_in = vra_pkg::ST_MOVE_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = vra_pkg::ST_FREE_RD;
            end
         end
         vra_pkg::ST_MOVE_RD: begin
            rd_addr  = IW'(count_ff - CW'(1));
            state_in = vra_pkg::ST_MOVE_WR;
         end
         vra_pkg::ST_MOVE_WR: begin
            wr_en    = 1'b1;
            wr_addr  = IW'(idx_ff);
            wr_data  = rd_data;
            count_in = count_ff - CW'(1);
            state_in = vra_pkg::ST_DONE;
         end
         vra_pkg::ST_DONE: begin
            rsp_in    = '0;
            rsp_in.ok = ok_ff;
            strobe_in = 1'b1;
            state_in  = vra_pkg::ST_IDLE;
         end
         default: state_in = vra_pkg::ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != vra_pkg::ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule
`default_nettype wire
